/* design/pwl_pkg.sv */
// Package for the pairwise linkage entropy table.
// Holds sizing constants, shared types and helper functions.
// Used by every module of the block but pwl_ram, and by its checker.
package pwl_pkg;

    localparam int GENES      = 32;
    localparam int COUNT_BITS = 16;
    localparam int PAIRS      = GENES * (GENES - 1) / 2;
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int SLOTS      = (PAIRS + LANES - 1) / LANES;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GIDX_W     = $clog2(GENES) + 1;
    localparam int CW         = COUNT_BITS;
    localparam int EW         = $clog2(COUNT_BITS);
    localparam int LOG_W      = EW + 16;
    localparam int PROD_W     = CW + LOG_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int DIST_W     = 17;
    localparam int LOG_STEPS  = 16;
    localparam int DIV_STEPS  = 16;
    localparam int LOG_VALUES = 9;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [DIST_W-1:0]     ONE_Q16   = DIST_W'(65536);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [GIDX_W-1:0] i;
        logic [GIDX_W-1:0] j;
    } pair_t;

    typedef struct packed {
        logic              start;
        logic              first;
        logic              pair_ok;
        logic              bit_i;
        logic              bit_j;
        logic [SLOT_W-1:0] slot;
    } lane_ctl_t;

    // Next pair in row order (i<j); once past the last pair it holds.
    function automatic pair_t next_pair(input pair_t p);
        pair_t n;
        n = p;
        if (p.i < GIDX_W'(GENES - 1))
        begin
            if (p.j < GIDX_W'(GENES - 1))
            begin
                n.j = p.j + 1'b1;
            end
            else
            begin
                n.i = p.i + 1'b1;
                n.j = p.i + GIDX_W'(2);
            end
        end
        return n;
    endfunction

    function automatic logic [15:0] pair_index(input logic [4:0] lo, input logic [4:0] hi);
        logic [15:0] l;
        l = 16'(lo);
        return l * 16'(GENES) - ((l * (l + 16'd1)) >> 1) + 16'(hi) - l - 16'd1;
    endfunction

endpackage

/* design/pwl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/pwl_lane.sv */
// One pair lane: owns the counters and distances of every LANES-th pair,
// updates a pair's counters and recomputes its distance with an iterative
// log2 unit and a restoring divider. Depends on pwl_pkg and pwl_ram.
module pwl_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pwl_pkg::lane_ctl_t        ctl,
    input  logic [pwl_pkg::SLOT_W-1:0] q_slot,
    output logic [pwl_pkg::DIST_W-1:0] q_dist,
    output logic                      done
);
    import pwl_pkg::*;

    typedef enum logic [6:0] {
        L_IDLE  = 7'b0000001,
        L_READ  = 7'b0000010,
        L_LOAD  = 7'b0000100,
        L_LOG   = 7'b0001000,
        L_DSET  = 7'b0010000,
        L_DIV   = 7'b0100000,
        L_WRITE = 7'b1000000
    } lane_state_t;

    lane_state_t state_reg, state_next;

    logic [SLOT_W-1:0]     slot_reg;
    logic                  first_reg, ok_reg;
    logic [1:0]            idx_reg;
    logic [CW-1:0]         cnt_reg [4];
    logic [CW-1:0]         cnt_next [4];
    logic [3:0]            v_reg, v_next;
    logic [4:0]            ph_reg, ph_next;
    logic [31:0]           x_reg, x_next;
    logic [15:0]           frac_reg, frac_next;
    logic [EW-1:0]         e_reg, e_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [ACC_W-1:0] j_reg, j_next, s_reg, s_next;
    logic [ACC_W-1:0]      r_reg, r_next;
    logic [15:0]           q_reg, q_next;
    logic [1:0]            kind_reg, kind_next;
    logic                  done_reg;

    logic [4*CW-1:0]       cnt_rdata, cnt_wdata;
    logic                  cnt_we, dist_we;
    logic [DIST_W-1:0]     dist_wdata;
    logic [CW-1:0]         cval;
    logic [EW-1:0]         lead;
    logic [63:0]           wide, sq;
    logic [32:0]           t;
    logic signed [ACC_W-1:0] pterm, num;
    logic [ACC_W-1:0]      r2;

    localparam logic [1:0] K_ZERO = 2'd0;
    localparam logic [1:0] K_ONE  = 2'd1;
    localparam logic [1:0] K_QUOT = 2'd2;

    pwl_ram #(.WIDTH(4 * CW), .DEPTH(SLOTS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (slot_reg),
        .wdata (cnt_wdata),
        .raddr (slot_reg),
        .rdata (cnt_rdata)
    );

    pwl_ram #(.WIDTH(DIST_W), .DEPTH(SLOTS)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (slot_reg),
        .wdata (dist_wdata),
        .raddr (q_slot),
        .rdata (q_dist)
    );

    // Operand of the current log step: total, four joint counts, four gene marginals.
    always_comb
    begin
        case (v_reg)
            4'd0:    cval = cnt_reg[0] + cnt_reg[1] + cnt_reg[2] + cnt_reg[3];
            4'd1:    cval = cnt_reg[0];
            4'd2:    cval = cnt_reg[1];
            4'd3:    cval = cnt_reg[2];
            4'd4:    cval = cnt_reg[3];
            4'd5:    cval = cnt_reg[0] + cnt_reg[2];
            4'd6:    cval = cnt_reg[1] + cnt_reg[3];
            4'd7:    cval = cnt_reg[0] + cnt_reg[1];
            4'd8:    cval = cnt_reg[2] + cnt_reg[3];
            default: cval = '0;
        endcase
    end

    always_comb
    begin
        lead = '0;
        for (int k = 0; k < CW; k++)
        begin
            if (cval[k])
            begin
                lead = EW'(k);
            end
        end
    end

    assign wide  = 64'(cval) << (5'd31 - 5'(lead));
    assign sq    = {32'b0, x_reg} * {32'b0, x_reg};
    assign t     = sq[63:31];
    assign pterm = $signed(ACC_W'(prod_reg));
    assign num   = (j_reg <<< 1) - s_reg;
    assign r2    = r_reg << 1;

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        ph_next    = ph_reg;
        x_next     = x_reg;
        frac_next  = frac_reg;
        e_next     = e_reg;
        prod_next  = prod_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        r_next     = r_reg;
        q_next     = q_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        cnt_we     = 1'b0;
        dist_we    = 1'b0;
        cnt_wdata  = {cnt_next[3], cnt_next[2], cnt_next[1], cnt_next[0]};
        case (kind_reg)
            K_ZERO:  dist_wdata = '0;
            K_ONE:   dist_wdata = ONE_Q16;
            default: dist_wdata = DIST_W'(q_reg);
        endcase
        case (state_reg)
            L_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = L_READ;
                end
            end
            L_READ:
            begin
                state_next = L_LOAD;
            end
            L_LOAD:
            begin
                // Before the first counted solution the counter memory holds nothing valid.
                for (int k = 0; k < 4; k++)
                begin
                    cnt_next[k] = first_reg ? '0 : cnt_rdata[k*CW +: CW];
                end
                cnt_next[idx_reg] = cnt_next[idx_reg] + 1'b1;
                cnt_wdata  = {cnt_next[3], cnt_next[2], cnt_next[1], cnt_next[0]};
                cnt_we     = ok_reg;
                v_next     = '0;
                ph_next    = '0;
                j_next     = '0;
                s_next     = '0;
                state_next = L_LOG;
            end
            L_LOG:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 5'd0)
                begin
                    e_next    = lead;
                    x_next    = wide[31:0];
                    frac_next = '0;
                end
                else if (ph_reg <= 5'(LOG_STEPS))
                begin
                    frac_next = {frac_reg[14:0], t[32]};
                    x_next    = t[32] ? t[32:1] : t[31:0];
                end
                else if (ph_reg == 5'(LOG_STEPS + 1))
                begin
                    prod_next = (cval < CW'(2)) ? '0 : PROD_W'(cval * {e_reg, frac_reg});
                end
                else
                begin
                    if (v_reg == 4'd0)
                    begin
                        j_next = j_reg + pterm;
                        s_next = s_reg + (pterm <<< 1);
                    end
                    else if (v_reg <= 4'd4)
                    begin
                        j_next = j_reg - pterm;
                    end
                    else
                    begin
                        s_next = s_reg - pterm;
                    end
                    ph_next = '0;
                    v_next  = v_reg + 1'b1;
                    if (v_reg == 4'(LOG_VALUES - 1))
                    begin
                        state_next = L_DSET;
                    end
                end
            end
            L_DSET:
            begin
                if (j_reg <= 0 || num <= 0)
                begin
                    kind_next = K_ZERO;
                end
                else if (num >= j_reg)
                begin
                    kind_next = K_ONE;
                end
                else
                begin
                    kind_next = K_QUOT;
                end
                r_next     = ACC_W'(num);
                q_next     = '0;
                ph_next    = '0;
                state_next = L_DIV;
            end
            L_DIV:
            begin
                // Fixed length so that all lanes stay in lockstep.
                if (r2 >= ACC_W'(j_reg))
                begin
                    r_next = r2 - ACC_W'(j_reg);
                    q_next = {q_reg[14:0], 1'b1};
                end
                else
                begin
                    r_next = r2;
                    q_next = {q_reg[14:0], 1'b0};
                end
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = L_WRITE;
                end
            end
            L_WRITE:
            begin
                dist_we    = ok_reg;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == L_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && ctl.start)
        begin
            slot_reg  <= ctl.slot;
            first_reg <= ctl.first;
            ok_reg    <= ctl.pair_ok;
            idx_reg   <= {ctl.bit_j, ctl.bit_i};
        end
        cnt_reg  <= cnt_next;
        v_reg    <= v_next;
        ph_reg   <= ph_next;
        x_reg    <= x_next;
        frac_reg <= frac_next;
        e_reg    <= e_next;
        prod_reg <= prod_next;
        j_reg    <= j_next;
        s_reg    <= s_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        kind_reg <= kind_next;
    end

    assign done = done_reg;
endmodule

/* design/pwl_merge.sv */
// Merging stage: joins the lane completion flags and picks the distance
// of the queried lane, or zero when force_zero is set. Depends on pwl_pkg.
module pwl_merge (
    input  logic [pwl_pkg::LANES-1:0]  lane_done,
    input  logic [pwl_pkg::DIST_W-1:0] lane_dist [pwl_pkg::LANES],
    input  logic [pwl_pkg::LANE_W-1:0] sel,
    input  logic                       force_zero,
    output logic                       all_done,
    output logic [pwl_pkg::DIST_W-1:0] sel_dist
);
    import pwl_pkg::*;

    assign all_done = &lane_done;
    assign sel_dist = force_zero ? '0 : lane_dist[sel];
endmodule

/* design/pairwise_linkage_entropy_table_unit.sv */
// Top level of the pairwise linkage entropy table.
// Depends on pwl_pkg, pwl_lane and pwl_merge.
//
//  channel | direction | handshake                  | payload
//  item    | in        | item_valid / item_stall    | opcode solution update_tables gene_a gene_b
//  result  | out       | result_valid / result_stall | distance population_count saturated
//
// A counted add walks all pairs in 62 slots of eight, one pair per lane per slot; each
// slot runs 9 log2 evaluations and a divide in every lane before the next slot starts.
// Queries read the distance memory through T_QRD and T_QSEL; uncounted or refused adds
// go straight from T_IDLE to T_DONE.
// Reset empties the tables at once: until the first counted add, memory contents are ignored.
// One item is in flight at a time; a held result keeps the next finished item waiting,
// which stalls the input.
module pairwise_linkage_entropy_table_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic                        opcode,
    input  logic [31:0]                 solution,
    input  logic                        update_tables,
    input  logic [4:0]                  gene_a,
    input  logic [4:0]                  gene_b,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [16:0]                 distance,
    output logic [15:0]                 population_count,
    output logic                        saturated
);
    import pwl_pkg::*;

    typedef enum logic [5:0] {
        T_IDLE  = 6'b000001,
        T_START = 6'b000010,
        T_WAIT  = 6'b000100,
        T_QRD   = 6'b001000,
        T_QSEL  = 6'b010000,
        T_DONE  = 6'b100000
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] pop_reg;
    logic                  first_reg;
    logic [31:0]           sol_reg;
    logic [SLOT_W-1:0]     slot_reg, q_slot_reg;
    logic [LANE_W-1:0]     q_lane_reg;
    logic                  q_zero_reg;
    pair_t                 base_reg;
    logic [DIST_W-1:0]     res_dist_reg;
    logic                  res_sat_reg;
    logic                  out_valid_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic [15:0]           out_pop_reg;
    logic                  out_sat_reg;

    pair_t                 chain [LANES+1];
    lane_ctl_t             ctl [LANES];
    logic [LANES-1:0]      lane_done;
    logic [DIST_W-1:0]     lane_dist [LANES];
    logic                  all_done;
    logic [DIST_W-1:0]     merged_dist;
    logic                  accept, load_out;
    logic [4:0]            lo, hi;
    logic [15:0]           pidx;

    assign accept   = item_valid && !item_stall;
    assign load_out = (state_reg == T_DONE) && (!out_valid_reg || !result_stall);
    assign lo       = (gene_a < gene_b) ? gene_a : gene_b;
    assign hi       = (gene_a < gene_b) ? gene_b : gene_a;
    assign pidx     = pair_index(lo, hi);

    assign chain[0] = base_reg;
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic [31:0] sh_i, sh_j;
        assign chain[k+1] = next_pair(chain[k]);
        assign sh_i = sol_reg >> chain[k].i;
        assign sh_j = sol_reg >> chain[k].j;
        assign ctl[k].start   = (state_reg == T_START);
        assign ctl[k].first   = first_reg;
        assign ctl[k].pair_ok = (chain[k].i < GIDX_W'(GENES - 1));
        assign ctl[k].bit_i   = sh_i[0];
        assign ctl[k].bit_j   = sh_j[0];
        assign ctl[k].slot    = slot_reg;

        pwl_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl[k]),
            .q_slot (q_slot_reg),
            .q_dist (lane_dist[k]),
            .done   (lane_done[k])
        );
    end

    pwl_merge u_merge (
        .lane_done  (lane_done),
        .lane_dist  (lane_dist),
        .sel        (q_lane_reg),
        .force_zero (q_zero_reg),
        .all_done   (all_done),
        .sel_dist   (merged_dist)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_QUERY)
                    begin
                        state_next = T_QRD;
                    end
                    else if (update_tables && pop_reg != COUNT_MAX)
                    begin
                        state_next = T_START;
                    end
                    else
                    begin
                        state_next = T_DONE;
                    end
                end
            end
            T_START: state_next = T_WAIT;
            T_WAIT:
            begin
                if (all_done)
                begin
                    state_next = (slot_reg == SLOT_W'(SLOTS - 1)) ? T_DONE : T_START;
                end
            end
            T_QRD:   state_next = T_QSEL;
            T_QSEL:  state_next = T_DONE;
            T_DONE:
            begin
                if (load_out)
                begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pop_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && opcode == OP_ADD && update_tables && pop_reg != COUNT_MAX)
            begin
                pop_reg <= pop_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sol_reg      <= solution;
            first_reg    <= (pop_reg == '0);
            slot_reg     <= '0;
            base_reg.i   <= '0;
            base_reg.j   <= GIDX_W'(1);
            res_dist_reg <= '0;
            res_sat_reg  <= (opcode == OP_ADD) && update_tables && (pop_reg == COUNT_MAX);
            q_slot_reg   <= SLOT_W'(pidx >> LANE_W);
            q_lane_reg   <= pidx[LANE_W-1:0];
            // Equal genes, an index past the gene count or empty tables all read as zero.
            q_zero_reg   <= (lo == hi) || (32'(hi) >= 32'(GENES)) || (pop_reg == '0);
        end
        if (state_reg == T_WAIT && all_done)
        begin
            slot_reg <= slot_reg + 1'b1;
            base_reg <= chain[LANES];
        end
        if (state_reg == T_QSEL)
        begin
            res_dist_reg <= merged_dist;
        end
        if (load_out)
        begin
            out_dist_reg <= res_dist_reg;
            out_pop_reg  <= 16'(pop_reg);
            out_sat_reg  <= res_sat_reg;
        end
    end

    assign item_stall       = (state_reg != T_IDLE);
    assign result_valid     = out_valid_reg;
    assign distance         = out_dist_reg;
    assign population_count = out_pop_reg;
    assign saturated        = out_sat_reg;
endmodule

/* design/pwl_checker.sv */
// Port-level checker for the pairwise linkage entropy table, bound to the top level.
// Depends on pwl_pkg.
module pwl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [16:0] distance,
    input logic [15:0] population_count,
    input logic        saturated
);
    import pwl_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(distance)
        && $stable(population_count) && $stable(saturated))
        else $error("stalled result changed");

    // Only one item is worked on at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second item taken while busy");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |-> distance == '0
        && population_count == 16'(COUNT_MAX))
        else $error("refused add with wrong fields");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && distance[16] |-> distance[15:0] == 16'd0)
        else $error("distance above one");
endmodule

bind pairwise_linkage_entropy_table_unit pwl_checker u_pwl_checker (.*);
